// ===== hdl/efb_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the frame builder.
// Used by every module of the frame builder; depends on nothing.
package efb_pkg;

    localparam int unsigned EFB_FIFO_DEPTH = 4;
    localparam int unsigned EFB_PTR_W      = $clog2(EFB_FIFO_DEPTH);
    localparam int unsigned EFB_CNT_W      = EFB_PTR_W + 1;

    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [7:0]  START_CODE  = 8'hFB;
    localparam logic [7:0]  PRE_FILL    = 8'h55;
    localparam logic [7:0]  DELIMITER   = 8'hD5;
    localparam logic [7:0]  IDLE_CODE   = 8'h07;
    localparam logic [5:0]  GAP_LIMIT   = 6'd32;

    localparam logic [1:0]  REG_DEST    = 2'd0;
    localparam logic [1:0]  REG_SOURCE  = 2'd1;
    localparam logic [1:0]  REG_LENGTH  = 2'd2;
    localparam logic [1:0]  REG_GAP     = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       first;
    } t_item;

    typedef struct packed {
        logic [47:0] dest;
        logic [47:0] source;
        logic [15:0] length;
        logic [5:0]  gap;
    } t_cfg;

    // Reflected CRC-32, one byte, bit by bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/efb_front.sv =====
// Input side: accepts payload bytes and marks the first byte of each frame.
// Depends on efb_pkg.
module efb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_payload_byte,
    input  logic           i_payload_last,
    input  logic           i_full,
    output logic           o_push,
    output efb_pkg::t_item o_item
);
    import efb_pkg::*;

    logic r_in_frame;

    assign o_ready     = !i_full;
    assign o_push      = i_valid && !i_full;
    assign o_item.data = i_payload_byte;
    assign o_item.last = i_payload_last;
    assign o_item.first = !r_in_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else if (o_push) begin
            r_in_frame <= !i_payload_last;
        end
    end

    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !i_payload_last) |=> r_in_frame)
        else $error("frame not opened after non-final byte");
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_payload_last) |=> !r_in_frame)
        else $error("frame not closed after final byte");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_full |-> !o_push)
        else $error("push into a full queue");

endmodule

// ===== hdl/efb_fifo.sv =====
// Short item queue between the input side and the byte sequencer.
// Depends on efb_pkg.
module efb_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  efb_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output efb_pkg::t_item o_item
);
    import efb_pkg::*;

    t_item                r_mem [EFB_FIFO_DEPTH];
    logic [EFB_PTR_W-1:0] r_wr_ptr;
    logic [EFB_PTR_W-1:0] r_rd_ptr;
    logic [EFB_CNT_W-1:0] r_count;

    assign o_full  = (r_count == EFB_CNT_W'(EFB_FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= EFB_CNT_W'(EFB_FIFO_DEPTH))
        else $error("queue count out of range");
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("pointers disagree on empty queue");

endmodule

// ===== hdl/efb_back.sv =====
// Byte sequencer: emits preamble, header, payload, FCS and idle fill, and
// runs the CRC-32. Holds the output register. Depends on efb_pkg.
module efb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  efb_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  efb_pkg::t_item i_q_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last
);
    import efb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PRE, S_HDR, S_DATA, S_FCS, S_GAP, S_PAD
    } t_state;

    t_state      r_state,     n_state;
    t_item       r_item,      n_item;
    logic [5:0]  r_cnt,       n_cnt;
    logic [31:0] r_crc,       n_crc;
    logic [1:0]  r_phase,     n_phase;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte,  n_out_byte;
    logic        r_out_last,  n_out_last;

    logic         adv;
    logic         emit;
    logic [7:0]   e_byte;
    logic         e_last;
    logic [1:0]   phase_after;
    logic [5:0]   gap_lim;
    logic [111:0] hdr;
    logic [111:0] hdr_sh;
    logic [31:0]  fcs_sh;

    assign adv         = !r_out_valid || i_ready;
    assign phase_after = r_phase + 2'd1;
    assign gap_lim     = (i_cfg.gap > GAP_LIMIT) ? GAP_LIMIT : i_cfg.gap;
    assign hdr         = {i_cfg.dest, i_cfg.source, i_cfg.length};
    assign hdr_sh      = hdr >> {(4'd13 - r_cnt[3:0]), 3'b000};
    assign fcs_sh      = (~r_crc) >> {r_cnt[1:0], 3'b000};

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_cnt       = r_cnt;
        n_crc       = r_crc;
        o_pop       = 1'b0;
        emit        = 1'b0;
        e_byte      = IDLE_CODE;
        e_last      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_q_item;
                    n_cnt   = '0;
                    n_state = i_q_item.first ? S_PRE : S_DATA;
                end
            end
            S_PRE: begin
                if (adv) begin
                    emit   = 1'b1;
                    e_byte = (r_cnt == 6'd0) ? START_CODE :
                             (r_cnt == 6'd7) ? DELIMITER : PRE_FILL;
                    if (r_cnt == 6'd0) begin
                        n_crc = CRC_INIT;
                    end
                    if (r_cnt == 6'd7) begin
                        n_cnt   = '0;
                        n_state = S_HDR;
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end
            end
            S_HDR: begin
                if (adv) begin
                    emit   = 1'b1;
                    e_byte = hdr_sh[7:0];
                    n_crc  = crc_byte(r_crc, hdr_sh[7:0]);
                    if (r_cnt == 6'd13) begin
                        n_cnt   = '0;
                        n_state = S_DATA;
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end
            end
            S_DATA: begin
                if (adv) begin
                    emit   = 1'b1;
                    e_byte = r_item.data;
                    n_crc  = crc_byte(r_crc, r_item.data);
                    if (r_item.last) begin
                        n_cnt   = '0;
                        n_state = S_FCS;
                    end else begin
                        e_last = 1'b1;
                        // take the next byte straight away to keep the stream gapless
                        if (i_q_valid) begin
                            o_pop   = 1'b1;
                            n_item  = i_q_item;
                            n_cnt   = '0;
                            n_state = i_q_item.first ? S_PRE : S_DATA;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_FCS: begin
                if (adv) begin
                    emit   = 1'b1;
                    e_byte = fcs_sh[7:0];
                    if (r_cnt == 6'd3) begin
                        if (gap_lim != 6'd0) begin
                            n_cnt   = gap_lim;
                            n_state = S_GAP;
                        end else if (phase_after != 2'd0) begin
                            n_state = S_PAD;
                        end else begin
                            e_last  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end
            end
            S_GAP: begin
                if (adv) begin
                    emit = 1'b1;
                    if (r_cnt == 6'd1) begin
                        if (phase_after != 2'd0) begin
                            n_state = S_PAD;
                        end else begin
                            e_last  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_PAD: begin
                if (adv) begin
                    emit = 1'b1;
                    if (phase_after == 2'd0) begin
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = e_byte;
            n_out_last  = e_last;
            n_phase     = phase_after;
        end else begin
            n_out_valid = r_out_valid && !i_ready;
            n_out_byte  = r_out_byte;
            n_out_last  = r_out_last;
            n_phase     = r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_crc       <= CRC_INIT;
            r_phase     <= 2'd0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_crc       <= n_crc;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_item     <= n_item;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_run_last = r_out_last;

    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRE && r_cnt == 6'd0) |-> (r_phase == 2'd0))
        else $error("frame starts off a four-byte boundary");
    a_gap_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GAP) |-> (r_cnt != 6'd0))
        else $error("gap counter underrun");
    a_first_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_item.first) |=> (r_state == S_PRE))
        else $error("frame start did not enter preamble");
    a_end_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && e_last && r_item.last) |=> (r_phase == 2'd0))
        else $error("frame closed off a four-byte boundary");

endmodule

// ===== hdl/ethernet_frame_builder_crc32_top.sv =====
// Top level of the frame builder: configuration registers, input side,
// item queue and byte sequencer. Depends on efb_pkg, efb_front, efb_fifo, efb_back.
//
// Input channel (i_valid/o_ready) carries one payload byte and a last flag.
// Output channel (o_valid/i_ready) carries one framed byte each transfer,
// with o_run_last high on the final byte caused by each input transfer.
// The first byte of a frame produces start code, six 0x55, 0xD5, the
// 14-byte header, then the byte; the last byte adds the FCS (least
// significant byte first), min_gap_bytes (at most 32) idle 0x07 bytes and 0x07 fill up
// to a four-byte boundary.
// With the sequencer idle, a payload byte passes the queue, the item register
// and the output register before its first output byte is offered. Throughput:
// one output byte per cycle while the receiver is ready and the sequencer is
// not idle; mid-frame bytes are taken one per cycle while queued. An input byte
// yields 1 output byte mid-frame, 23 at frame start and 5 + gap + fill at frame end.
// The 4-entry queue absorbs input while the sequencer is busy; on a receiver
// stall the output register holds its byte and o_ready drops once it fills.
// Reset (synchronous, active low) empties the queue, closes any open frame
// and clears the configuration and the sequencer state, with min_gap_bytes at
// 12. Write configuration only while the block is idle.
module ethernet_frame_builder_crc32_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_payload_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last
);
    import efb_pkg::*;

    t_cfg  r_cfg;
    t_item push_item;
    t_item q_item;
    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest   <= '0;
            r_cfg.source <= '0;
            r_cfg.length <= '0;
            r_cfg.gap    <= 6'd12;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEST:   r_cfg.dest   <= i_cfg_data;
                REG_SOURCE: r_cfg.source <= i_cfg_data;
                REG_LENGTH: r_cfg.length <= i_cfg_data[15:0];
                REG_GAP:    r_cfg.gap    <= i_cfg_data[5:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    efb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_payload_byte (i_payload_byte),
        .i_payload_last (i_payload_last),
        .i_full         (full),
        .o_push         (push),
        .o_item         (push_item)
    );

    efb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    efb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

endmodule
